/* rtl/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the counter to nanosecond converter: the
// transaction payloads, the configuration bundle, register indexes and the
// sequencer states.
// ----------------------------------------------------------------------------
package tsc_pkg;

   typedef struct packed {
      logic        cmd;
      logic [63:0] counter_value;
      logic [63:0] reference_ns;
   } req_type;

   typedef struct packed {
      logic [63:0] time_ns;
      logic [31:0] scale_now;
      logic        is_initialized;
   } rsp_type;

   typedef struct packed {
      logic signed [6:0] tsc_shift;
      logic [31:0]       initial_scale;
   } cfg_type;

   // Register index, taken from the word address.
   localparam logic REG_TSC_SHIFT     = 1'b0;
   localparam logic REG_INITIAL_SCALE = 1'b1;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // Error magnitude at or above which the trim clamps to the limit.
   localparam logic [63:0] ERR_SAT_MAG  = 64'd101000;
   localparam logic [6:0]  PPM_LIMIT    = 7'd100;
   // Ceiling of 2^27 / 1000; exact for error magnitudes below the clamp.
   localparam logic [31:0] RECIP_1000   = 32'd134218;
   // Floor of 2^40 / 1000000; the estimate is low by at most one.
   localparam logic [31:0] RECIP_PPM    = 32'd1099511;
   localparam logic [31:0] PPM_DIV      = 32'd1000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ADD,
      ST_DIFF,
      ST_QMUL,
      ST_TMUL,
      ST_EST,
      ST_BACK,
      ST_FIX,
      ST_DONE
   } state_type;

endpackage

/* rtl/tsc_csr.sv */
// ----------------------------------------------------------------------------
// tsc_csr
// Configuration registers behind an APB-style port: the signed pre-shift and
// the initial 0.32 scale. Always ready, no wait states.
// ----------------------------------------------------------------------------
module tsc_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output tsc_pkg::cfg_type   cfg
);

   logic signed [6:0] tsc_shift_ff;
   logic [31:0]       initial_scale_ff;
   logic              wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tsc_shift_ff     <= 7'sd0;
         initial_scale_ff <= 32'd0;
      end else if (wr_en) begin
         unique case (paddr[2])
            tsc_pkg::REG_TSC_SHIFT:     tsc_shift_ff     <= pwdata[6:0];
            tsc_pkg::REG_INITIAL_SCALE: initial_scale_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         tsc_pkg::REG_TSC_SHIFT:     prdata = 32'(tsc_shift_ff);
         tsc_pkg::REG_INITIAL_SCALE: prdata = initial_scale_ff;
         default:                    prdata = 32'd0;
      endcase
   end

   assign cfg.tsc_shift     = tsc_shift_ff;
   assign cfg.initial_scale = initial_scale_ff;

endmodule

/* rtl/tsc_mul.sv */
// ----------------------------------------------------------------------------
// tsc_mul
// Shared 32 x 32 unsigned multiplier with a registered product. Every
// multiplication of the converter and of the drift trim goes through it.
// ----------------------------------------------------------------------------
module tsc_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);

   logic [63:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= {32'd0, op_a} * {32'd0, op_b};
   end

   assign product = product_ff;

endmodule

/* rtl/tsc_to_ns_with_drift_trim_unit.sv */
// ----------------------------------------------------------------------------
// tsc_to_ns_with_drift_trim_unit
// Converts cycle counter samples to nanoseconds through a 0.32 scale and
// trims the scale in parts per million against a reference time on updates.
//
//   Channel   Ports                      Direction  Payload
//   request   req_valid/req_ready/req_*  in         cmd, counter, reference
//   response  rsp_valid/rsp_ready/rsp_*  out        time, scale, initialized
//   config    psel..pready (APB style)   in/out     tsc_shift, initial_scale
//
// A read runs the pre-shift, two multiplier passes and the add; a first
// update goes straight to the result and a later update adds the trim,
// with four passes of the one registered 32 x 32 multiplier. One
// transaction is in flight at a time; the result sits in an output
// register, so the next transaction is taken while it waits. A stall on
// the response side holds the sequencer only in its final step. Reset is
// synchronous and clears the state and the configuration.
// ----------------------------------------------------------------------------
module tsc_to_ns_with_drift_trim_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tsc_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tsc_pkg::rsp_type   rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   tsc_pkg::cfg_type   cfg;
   tsc_pkg::state_type state_ff, state_in;

   logic        initialized_ff, initialized_in;
   logic [63:0] base_ns_ff, base_ns_in;
   logic [63:0] base_count_ff, base_count_in;
   logic [31:0] scale_ff, scale_in;

   logic        cmd_ff, cmd_in;
   logic [63:0] counter_ff, counter_in;
   logic [63:0] ref_ff, ref_in;
   logic [63:0] delta_ff, delta_in;
   logic [31:0] conv_ff, conv_in;
   logic [63:0] res_time_ff, res_time_in;
   logic [16:0] mag_ff, mag_in;
   logic        sat_ff, sat_in;
   logic        neg_ff, neg_in;
   logic [38:0] t_ff, t_in;
   logic [19:0] est_ff, est_in;

   logic             rsp_valid_ff, rsp_valid_in;
   tsc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] product;

   logic [63:0] elapsed;
   logic [63:0] shifted;
   logic [6:0]  right_amt;
   logic [31:0] conv_sum;
   logic [63:0] time_sum;
   logic [63:0] diff;
   logic [63:0] mag;
   logic [6:0]  ppm;
   logic [38:0] rem;
   logic [19:0] corr;
   logic [32:0] scale_up;

   tsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tsc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   // Signed pre-shift of the elapsed count; a right shift of 64 gives zero.
   always_comb begin
      elapsed   = counter_ff - base_count_ff;
      right_amt = 7'(7'd0 - cfg.tsc_shift);
      if (cfg.tsc_shift[6]) begin
         shifted = right_amt[6] ? 64'd0 : (elapsed >> right_amt[5:0]);
      end else begin
         shifted = elapsed << cfg.tsc_shift[5:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      initialized_in = initialized_ff;
      base_ns_in     = base_ns_ff;
      base_count_in  = base_count_ff;
      scale_in       = scale_ff;
      cmd_in         = cmd_ff;
      counter_in     = counter_ff;
      ref_in         = ref_ff;
      delta_in       = delta_ff;
      conv_in        = conv_ff;
      res_time_in    = res_time_ff;
      mag_in         = mag_ff;
      sat_in         = sat_ff;
      neg_in         = neg_ff;
      t_in           = t_ff;
      est_in         = est_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_data_in    = rsp_data_ff;
      mul_a          = 32'd0;
      mul_b          = 32'd0;
      req_ready      = 1'b0;

      // Only the low 64 bits of the product count, so the high half of the
      // elapsed count contributes just the low word of its partial product.
      conv_sum = conv_ff + product[31:0];
      time_sum = base_ns_ff + {32'd0, conv_sum};
      diff     = ref_ff - base_ns_ff;
      mag      = diff[63] ? (~diff + 64'd1) : diff;
      ppm      = sat_ff ? tsc_pkg::PPM_LIMIT : product[33:27];
      rem      = t_ff - product[38:0];
      corr     = (rem >= 39'(tsc_pkg::PPM_DIV)) ? (est_ff + 20'd1) : est_ff;
      scale_up = {1'b0, scale_ff} + {13'd0, corr};

      unique case (state_ff)
         tsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               counter_in = req_data.counter_value;
               ref_in     = req_data.reference_ns;
               if (req_data.cmd == tsc_pkg::CMD_UPDATE && !initialized_ff) begin
                  scale_in       = cfg.initial_scale;
                  base_ns_in     = req_data.reference_ns;
                  base_count_in  = req_data.counter_value;
                  initialized_in = 1'b1;
                  res_time_in    = req_data.reference_ns;
                  state_in       = tsc_pkg::ST_DONE;
               end else begin
                  state_in = tsc_pkg::ST_SHIFT;
               end
            end
         end
         tsc_pkg::ST_SHIFT: begin
            delta_in = shifted;
            state_in = tsc_pkg::ST_MUL_LO;
         end
         tsc_pkg::ST_MUL_LO: begin
            mul_a    = delta_ff[31:0];
            mul_b    = scale_ff;
            state_in = tsc_pkg::ST_MUL_HI;
         end
         tsc_pkg::ST_MUL_HI: begin
            conv_in  = product[63:32];
            mul_a    = delta_ff[63:32];
            mul_b    = scale_ff;
            state_in = tsc_pkg::ST_ADD;
         end
         tsc_pkg::ST_ADD: begin
            res_time_in = time_sum;
            if (cmd_ff == tsc_pkg::CMD_READ) begin
               state_in = tsc_pkg::ST_DONE;
            end else begin
               base_ns_in    = time_sum;
               base_count_in = counter_ff;
               state_in      = tsc_pkg::ST_DIFF;
            end
         end
         tsc_pkg::ST_DIFF: begin
            neg_in   = diff[63];
            sat_in   = mag >= tsc_pkg::ERR_SAT_MAG;
            mag_in   = mag[16:0];
            state_in = tsc_pkg::ST_QMUL;
         end
         tsc_pkg::ST_QMUL: begin
            // Error divided by 1000 through the reciprocal.
            mul_a    = {15'd0, mag_ff};
            mul_b    = tsc_pkg::RECIP_1000;
            state_in = tsc_pkg::ST_TMUL;
         end
         tsc_pkg::ST_TMUL: begin
            mul_a    = scale_ff;
            mul_b    = {25'd0, ppm};
            state_in = tsc_pkg::ST_EST;
         end
         tsc_pkg::ST_EST: begin
            t_in     = product[38:0];
            mul_a    = {1'b0, product[38:8]};
            mul_b    = tsc_pkg::RECIP_PPM;
            state_in = tsc_pkg::ST_BACK;
         end
         tsc_pkg::ST_BACK: begin
            est_in   = product[51:32];
            mul_a    = {12'd0, product[51:32]};
            mul_b    = tsc_pkg::PPM_DIV;
            state_in = tsc_pkg::ST_FIX;
         end
         tsc_pkg::ST_FIX: begin
            // The quotient estimate is low by at most one; the remainder
            // check settles it before the saturating scale update.
            if (neg_ff) begin
               scale_in = scale_up[32] ? 32'hFFFF_FFFF : scale_up[31:0];
            end else begin
               scale_in = ({12'd0, corr} > scale_ff) ? 32'd0
                                                      : (scale_ff - {12'd0, corr});
            end
            state_in = tsc_pkg::ST_DONE;
         end
         tsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.time_ns        = res_time_ff;
               rsp_data_in.scale_now      = scale_ff;
               rsp_data_in.is_initialized = initialized_ff;
               state_in                   = tsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tsc_pkg::ST_IDLE;
         initialized_ff <= 1'b0;
         base_ns_ff     <= 64'd0;
         base_count_ff  <= 64'd0;
         scale_ff       <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         initialized_ff <= initialized_in;
         base_ns_ff     <= base_ns_in;
         base_count_ff  <= base_count_in;
         scale_ff       <= scale_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      counter_ff  <= counter_in;
      ref_ff      <= ref_in;
      delta_ff    <= delta_in;
      conv_ff     <= conv_in;
      res_time_ff <= res_time_in;
      mag_ff      <= mag_in;
      sat_ff      <= sat_in;
      neg_ff      <= neg_in;
      t_ff        <= t_in;
      est_ff      <= est_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/tsc_time_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_time_checker
// Watches the request, response and register ports of the counter to
// nanosecond converter. It keeps its own copy of the base time, base
// counter, scale and registers, predicts each result and compares it field
// by field.
// ----------------------------------------------------------------------------
module tsc_time_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tsc_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tsc_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output int                mismatches,
   output int                in_flight,
   output int                compared
);

   localparam logic [63:0] NS_PER_PPM_STEP = 64'd1000;
   localparam logic [63:0] MICRO_DIV       = 64'd1000000;
   localparam logic [63:0] TRIM_CLAMP      = 64'd100;
   localparam logic [63:0] SCALE_CEIL      = 64'h0000_0000_FFFF_FFFF;

   logic              trk_live;
   logic [63:0]       trk_base_ns;
   logic [63:0]       trk_base_tsc;
   logic [31:0]       trk_scale;
   logic signed [6:0] shift_cfg;
   logic [31:0]       seed_scale_cfg;
   tsc_pkg::rsp_type  expected_times[$];
   int                fail_total;
   int                result_total;

   assign mismatches = fail_total;
   assign compared   = result_total;

   // Counts since the base, pre-shifted, times the 0.32 scale, mod 2^64.
   function automatic logic [63:0] scaled_elapsed(input logic [63:0] tsc);
      logic [63:0] span;
      logic [6:0]  right_amt;
      span = tsc - trk_base_tsc;
      if (shift_cfg < 0) begin
         right_amt = ~shift_cfg + 7'd1;
         span = (right_amt >= 7'd64) ? 64'd0 : span >> right_amt;
      end else begin
         span = span << shift_cfg;
      end
      span = span * {32'd0, trk_scale};
      return span >> 32;
   endfunction

   function automatic tsc_pkg::rsp_type predict_time(input tsc_pkg::req_type rq);
      tsc_pkg::rsp_type rs;
      logic [63:0]      err;
      logic [63:0]      mag;
      logic [63:0]      ppm;
      logic [63:0]      trim;
      logic [63:0]      grown;
      if (rq.cmd == tsc_pkg::CMD_READ) begin
         rs.time_ns = trk_base_ns + scaled_elapsed(rq.counter_value);
      end else if (!trk_live) begin
         trk_scale    = seed_scale_cfg;
         trk_base_ns  = rq.reference_ns;
         trk_base_tsc = rq.counter_value;
         trk_live     = 1'b1;
         rs.time_ns   = trk_base_ns;
      end else begin
         trk_base_ns  = trk_base_ns + scaled_elapsed(rq.counter_value);
         trk_base_tsc = rq.counter_value;
         err = rq.reference_ns - trk_base_ns;
         mag = err[63] ? (~err + 64'd1) : err;
         ppm = mag / NS_PER_PPM_STEP;
         if (ppm > TRIM_CLAMP) begin
            ppm = TRIM_CLAMP;
         end
         trim = ({32'd0, trk_scale} * ppm) / MICRO_DIV;
         // A reference behind the base time speeds the scale up.
         if (err[63]) begin
            grown = {32'd0, trk_scale} + trim;
            trk_scale = (grown > SCALE_CEIL) ? 32'hFFFF_FFFF : grown[31:0];
         end else begin
            trk_scale = (trim > {32'd0, trk_scale}) ? 32'd0 : trk_scale - trim[31:0];
         end
         rs.time_ns = trk_base_ns;
      end
      rs.scale_now      = trk_scale;
      rs.is_initialized = trk_live;
      return rs;
   endfunction

   always @(posedge clock) begin
      tsc_pkg::rsp_type want;
      if (reset) begin
         trk_live       = 1'b0;
         trk_base_ns    = 64'd0;
         trk_base_tsc   = 64'd0;
         trk_scale      = 32'd0;
         shift_cfg      = 7'sd0;
         seed_scale_cfg = 32'd0;
         expected_times.delete();
         fail_total     = 0;
         result_total   = 0;
         in_flight     <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_times.size() == 0) begin
               $display("%0t: result %h arrived with no transaction pending",
                        $time, rsp_data);
               fail_total++;
            end else begin
               want = expected_times.pop_front();
               result_total++;
               if (rsp_data.time_ns !== want.time_ns) begin
                  $display("%0t: time_ns expected %h actual %h",
                           $time, want.time_ns, rsp_data.time_ns);
                  fail_total++;
               end
               if (rsp_data.scale_now !== want.scale_now) begin
                  $display("%0t: scale_now expected %h actual %h",
                           $time, want.scale_now, rsp_data.scale_now);
                  fail_total++;
               end
               if (rsp_data.is_initialized !== want.is_initialized) begin
                  $display("%0t: is_initialized expected %b actual %b",
                           $time, want.is_initialized, rsp_data.is_initialized);
                  fail_total++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == tsc_pkg::REG_TSC_SHIFT) begin
               shift_cfg = pwdata[6:0];
            end else begin
               seed_scale_cfg = pwdata;
            end
         end
         if (req_valid && req_ready) begin
            expected_times.push_back(predict_time(req_data));
         end
         in_flight <= expected_times.size();
      end
   end

endmodule

/* tb/sv/tsc_to_ns_with_drift_trim_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_to_ns_with_drift_trim_unit_test
// Drives the converter with directed corner cases and then with runs of
// updates whose reference times sit near the expected base time, mixed with
// fully random transactions, over several shift and scale settings. Both
// sides idle at random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tsc_to_ns_with_drift_trim_unit_test;

   localparam int NUM_SETTINGS      = 12;
   localparam int ITEMS_PER_SETTING = 150;
   localparam int HOLD_OFF_CYCLES   = 300;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tsc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tsc_pkg::rsp_type rsp_data;
   logic             psel      = 1'b0;
   logic             penable   = 1'b0;
   logic             pwrite    = 1'b0;
   logic [2:0]       paddr     = 3'd0;
   logic [31:0]      pwdata    = 32'd0;
   logic [31:0]      prdata;
   logic             pready;

   int          mismatches;
   int          in_flight;
   int          compared;

   bit                no_gaps      = 1'b0;
   bit                hold_off_req = 1'b0;
   tsc_pkg::rsp_type  last_rsp     = '0;
   logic signed [6:0] cur_shift    = 7'sd0;
   logic [63:0]       tb_base_ns   = 64'd0;
   logic [63:0]       tb_base_tsc  = 64'd0;
   logic [31:0]       tb_scale     = 32'd0;
   int                n_reads      = 0;
   int                n_updates    = 0;
   int                n_writes     = 0;

   tsc_to_ns_with_drift_trim_unit i_dut (.*);

   tsc_time_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .in_flight  (in_flight),
      .compared   (compared)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Timeout with %0d transactions outstanding", in_flight);
      $display("Mismatches found");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            last_rsp = rsp_data;
         end
         if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_gaps || ($urandom_range(99) >= 30);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Rough conversion with the last scale seen; good enough to aim references.
   function automatic logic [63:0] approx_ns(input logic [63:0] elapsed);
      logic [63:0] span;
      if (cur_shift < 0) begin
         span = (cur_shift == -64) ? 64'd0 : elapsed >> (7'd0 - cur_shift);
      end else begin
         span = elapsed << cur_shift;
      end
      span = span * {32'd0, tb_scale};
      return span >> 32;
   endfunction

   task automatic send(input logic cmd, input logic [63:0] tsc, input logic [63:0] ref_ns);
      tsc_pkg::req_type item;
      item.cmd           = cmd;
      item.counter_value = tsc;
      item.reference_ns  = ref_ns;
      if (cmd == tsc_pkg::CMD_UPDATE) begin
         tb_base_tsc = tsc;
      end
      if (!no_gaps && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == tsc_pkg::CMD_READ) begin
         n_reads++;
      end else begin
         n_updates++;
      end
   endtask

   // Stop offering and wait until every transaction has its result.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (in_flight == 0);
      repeat (4) @(posedge clock);
   endtask

   // The last transaction before a drain is always an update, so its result
   // holds the current base time and scale.
   task automatic resync();
      drain();
      tb_base_ns = last_rsp.time_ns;
      tb_scale   = last_rsp.scale_now;
   endtask

   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      n_writes++;
   endtask

   task automatic set_config(input logic signed [6:0] shift, input logic [31:0] seed);
      drain();
      csr_write(tsc_pkg::REG_TSC_SHIFT, {{25{shift[6]}}, shift});
      csr_write(tsc_pkg::REG_INITIAL_SCALE, seed);
      cur_shift = shift;
   endtask

   // Updates aimed near the expected base time, so most trims stay inside
   // the clamp, with reads scattered around the base counter.
   task automatic tracked_run();
      int                 len;
      int                 pick;
      logic [63:0]        step;
      logic signed [63:0] err_ns;
      len = $urandom_range(2, 12);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(7))
            0:       step = 64'd0;
            1:       step = {32'd0, $urandom};
            default: step = 64'($urandom_range(1 << 20));
         endcase
         if (k < len - 1 && $urandom_range(1) == 1) begin
            if ($urandom_range(9) == 0) begin
               send(tsc_pkg::CMD_READ, tb_base_tsc - step, rand64());
            end else begin
               send(tsc_pkg::CMD_READ, tb_base_tsc + step, rand64());
            end
         end else begin
            tb_base_ns = tb_base_ns + approx_ns(step);
            case ($urandom_range(9))
               0: err_ns = 0;
               1: begin
                  pick = $urandom_range(3);
                  case (pick)
                     0:       err_ns = 999;
                     1:       err_ns = 1000;
                     2:       err_ns = 100999;
                     default: err_ns = 101000;
                  endcase
                  if ($urandom_range(1) == 1) begin
                     err_ns = -err_ns;
                  end
               end
               default: begin
                  pick   = $urandom_range(260000);
                  err_ns = 64'(pick - 130000);
               end
            endcase
            send(tsc_pkg::CMD_UPDATE, tb_base_tsc + step, tb_base_ns + err_ns);
         end
      end
   endtask

   task automatic noise_run();
      int len;
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
         if (k == len - 1 || $urandom_range(1) == 0) begin
            send(tsc_pkg::CMD_UPDATE, rand64(), rand64());
         end else begin
            send(tsc_pkg::CMD_READ, rand64(), rand64());
         end
      end
   endtask

   initial begin
      logic signed [6:0] sh;
      logic [31:0]       seed;
      int                start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reads before the first update see the cleared state.
      send(tsc_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(tsc_pkg::CMD_READ, 64'd0, 64'd0);
      set_config(7'sd0, 32'hFFFF_F000);
      send(tsc_pkg::CMD_UPDATE, 64'h0000_0000_1000_0000, 64'd1_000_000_000);
      tb_base_ns = 64'd1_000_000_000;
      tb_scale   = 32'hFFFF_F000;
      send(tsc_pkg::CMD_READ, tb_base_tsc + 64'd1000, 64'd0);
      send(tsc_pkg::CMD_READ, tb_base_tsc - 64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send(tsc_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      tb_base_ns = tb_base_ns + approx_ns(64'd1_000_000);
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc + 64'd1_000_000, tb_base_ns + 64'd500);
      // Far-behind references push the scale into saturation at the top.
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc + 64'd2_000_000, 64'hFFFF_FFFF_FFFF_FFFF);
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc, 64'd0);
      resync();
      // Same counter, so the base holds and the error is exact.
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc, tb_base_ns + 64'h8000_0000_0000_0000);
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc, tb_base_ns + 64'h7FFF_FFFF_FFFF_FFFF);
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc, tb_base_ns + 64'd100999);
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc, tb_base_ns - 64'd101000);
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc, tb_base_ns + 64'd999);
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc, tb_base_ns - 64'd1000);
      set_config(-7'sd64, 32'd0);
      send(tsc_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, rand64());
      set_config(7'sd63, 32'hFFFF_FFFF);
      send(tsc_pkg::CMD_READ, tb_base_tsc + 64'd3, rand64());
      set_config(-7'sd63, 32'h8000_0001);
      send(tsc_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, rand64());
      send(tsc_pkg::CMD_UPDATE, tb_base_tsc + 64'd5, rand64());

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         case (p)
            0:       sh = 7'sd0;
            1:       sh = -7'sd64;
            2:       sh = 7'sd63;
            3:       sh = -7'sd32;
            4:       sh = 7'sd32;
            5:       sh = -7'sd1;
            default: sh = 7'($urandom_range(127));
         endcase
         case (p % 3)
            0:       seed = 32'hFFFF_FFFF;
            1:       seed = 32'd0;
            default: seed = $urandom;
         endcase
         set_config(sh, seed);
         no_gaps = (p == 3);
         if (p == 5) begin
            hold_off_req = 1'b1;
         end
         start = n_reads + n_updates;
         while (n_reads + n_updates - start < ITEMS_PER_SETTING) begin
            if ($urandom_range(9) < 8) begin
               resync();
               tracked_run();
            end else begin
               noise_run();
            end
         end
      end
      no_gaps = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d updates and %0d reads across %0d register writes,",
               n_updates, n_reads, n_writes);
      $display("with shifts from -64 to 63; %0d results checked.", compared);
      if (mismatches == 0 && in_flight == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
